// File: hdl/xor_checked_frame_receiver_macros.svh
// Assertion helpers used by the receiver's top-level RTL file.
`ifndef XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Property that holds in the same cycle as its trigger.
`define XCFR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver assertion failed");

// Property that holds in the cycle after its trigger.
`define XCFR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver assertion failed");

`endif

// File: hdl/xcfr_pkg.sv
package xcfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 6;
    localparam int IDX_W     = 5;
    localparam int CFG_IDX_W = 4;
    // At most this many results come out of one frame.
    localparam int MAX_RES   = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START   = 4'd0,
        CFG_END     = 4'd1,
        CFG_MAX_LEN = 4'd2,
        CFG_ID_A    = 4'd3,
        CFG_ID_B    = 4'd4,
        CFG_ID_C    = 4'd5,
        CFG_ID_D    = 4'd6,
        CFG_ID_E    = 4'd7
    } cfg_reg_t;

    // Frame parser steps.
    typedef enum logic [2:0] {
        PS_SOF  = 3'd0,
        PS_LEN  = 3'd1,
        PS_ID   = 3'd2,
        PS_DATA = 3'd3,
        PS_CHK  = 3'd4,
        PS_EOT  = 3'd5,
        PS_SKIP = 3'd6
    } parse_step_t;

    // Payload drain sequencer states.
    typedef enum logic [1:0] {
        DRN_IDLE  = 2'd0,
        DRN_EMPTY = 2'd1,
        DRN_READ  = 2'd2
    } drain_state_t;

    // Events from the parser: payload write and frame accepted.
    typedef struct packed {
        logic              wr_en;
        logic [LEN_W-1:0]  wr_pos;
        logic [BYTE_W-1:0] wr_data;
        logic              done;
        logic [BYTE_W-1:0] id;
        logic [LEN_W-1:0]  length;
    } xcfr_evt_t;

endpackage

// File: hdl/xcfr_parser.sv
module xcfr_parser
    import xcfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 byte_valid,
    input  logic [BYTE_W-1:0]    rx_byte,
    output xcfr_evt_t            evt
);

    localparam logic [LEN_W:0] PAY_LIMIT = (LEN_W + 1)'(MAX_PAYLOAD);

    logic [BYTE_W-1:0] start_reg, end_reg;
    logic [LEN_W-1:0]  max_len_reg;
    logic [BYTE_W-1:0] id_a_reg, id_b_reg, id_c_reg, id_d_reg, id_e_reg;

    parse_step_t       step_reg, step_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic [BYTE_W-1:0] held_id_reg, held_id_next;
    logic [LEN_W-1:0]  held_len_reg, held_len_next;

    logic [LEN_W:0]    limit;
    logic              len_ok, id_ok, chk_ok, is_start, is_end;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= 8'd2;
            end_reg     <= 8'd3;
            max_len_reg <= 6'd32;
            id_a_reg    <= 8'd1;
            id_b_reg    <= 8'd2;
            id_c_reg    <= 8'd3;
            id_d_reg    <= 8'd4;
            id_e_reg    <= 8'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START:   start_reg   <= cfg_data;
                CFG_END:     end_reg     <= cfg_data;
                CFG_MAX_LEN: max_len_reg <= cfg_data[LEN_W-1:0];
                CFG_ID_A:    id_a_reg    <= cfg_data;
                CFG_ID_B:    id_b_reg    <= cfg_data;
                CFG_ID_C:    id_c_reg    <= cfg_data;
                CFG_ID_D:    id_d_reg    <= cfg_data;
                CFG_ID_E:    id_e_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Byte checks against the configuration.
    always_comb
    begin
        limit    = ({1'b0, max_len_reg} < PAY_LIMIT) ? {1'b0, max_len_reg} : PAY_LIMIT;
        len_ok   = rx_byte <= {{(BYTE_W - LEN_W - 1){1'b0}}, limit};
        id_ok    = (rx_byte == id_a_reg) || (rx_byte == id_b_reg) ||
                   (rx_byte == id_c_reg) || (rx_byte == id_d_reg) ||
                   (rx_byte == id_e_reg);
        chk_ok   = rx_byte == xor_reg;
        is_start = rx_byte == start_reg;
        is_end   = rx_byte == end_reg;
    end

    // Next parse step.
    always_comb
    begin
        step_next = step_reg;
        if (byte_valid)
        begin
            unique case (step_reg)
                PS_SKIP: step_next = is_end ? PS_SOF : PS_SKIP;
                PS_LEN:  step_next = len_ok ? PS_ID : PS_SKIP;
                PS_ID:
                begin
                    if (!id_ok)
                        step_next = PS_SKIP;
                    else
                        step_next = (left_reg == '0) ? PS_CHK : PS_DATA;
                end
                PS_DATA: step_next = (left_reg <= LEN_W'(1)) ? PS_CHK : PS_DATA;
                PS_CHK:  step_next = chk_ok ? PS_EOT : PS_SKIP;
                PS_EOT:  step_next = is_end ? PS_SOF : PS_SKIP;
                default: step_next = is_start ? PS_LEN : PS_SKIP;
            endcase
        end
    end

    // Frame fields, checksum and write/accept events.
    always_comb
    begin
        xor_next      = xor_reg;
        left_next     = left_reg;
        held_id_next  = held_id_reg;
        held_len_next = held_len_reg;
        evt.wr_en     = 1'b0;
        evt.wr_pos    = held_len_reg - left_reg;
        evt.wr_data   = rx_byte;
        evt.done      = 1'b0;
        evt.id        = held_id_reg;
        evt.length    = held_len_reg;
        if (byte_valid)
        begin
            unique case (step_reg)
                PS_SKIP, PS_CHK: ;
                PS_LEN:
                begin
                    if (len_ok)
                    begin
                        held_len_next = rx_byte[LEN_W-1:0];
                        left_next     = rx_byte[LEN_W-1:0];
                        xor_next      = xor_reg ^ rx_byte;
                    end
                end
                PS_ID:
                begin
                    if (id_ok)
                    begin
                        held_id_next = rx_byte;
                        xor_next     = xor_reg ^ rx_byte;
                    end
                end
                PS_DATA:
                begin
                    evt.wr_en = 1'b1;
                    xor_next  = xor_reg ^ rx_byte;
                    if (left_reg != '0)
                        left_next = left_reg - LEN_W'(1);
                end
                PS_EOT: evt.done = is_end;
                default:
                begin
                    if (is_start)
                    begin
                        xor_next  = '0;
                        left_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= PS_SOF;
            xor_reg      <= '0;
            left_reg     <= '0;
            held_id_reg  <= '0;
            held_len_reg <= '0;
        end
        else
        begin
            step_reg     <= step_next;
            xor_reg      <= xor_next;
            left_reg     <= left_next;
            held_id_reg  <= held_id_next;
            held_len_reg <= held_len_next;
        end
    end

endmodule

// File: hdl/xor_checked_frame_receiver.sv
// Frame receiver with XOR checksum. Each received byte is one input item and
// is taken in the cycle it is offered while no frame is draining. Payload
// bytes go into a MAX_PAYLOAD-entry synchronous memory; when the end byte of a
// good frame is accepted, input stalls while the payload is read back one
// entry at a time. Each result is a memory read followed by an output load,
// and no new read is issued while one is still in flight; an empty frame
// gives a single result, and a stalled output holds the drain. At most 32
// results come from one frame. The memory needs no clearing after reset.
`include "xor_checked_frame_receiver_macros.svh"

module xor_checked_frame_receiver
    import xcfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    frame_id,
    output logic [BYTE_W-1:0]    payload_byte,
    output logic [IDX_W-1:0]     byte_index,
    output logic [LEN_W-1:0]     frame_length,
    output logic                 empty_frame,
    output logic                 last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    xcfr_evt_t         evt;
    logic              in_accept;

    logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] rd_data_reg;

    drain_state_t      drn_state_reg, drn_state_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_pend_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic              pend_last_reg;
    logic [BYTE_W-1:0] drn_id_reg;
    logic [LEN_W-1:0]  drn_len_reg;
    logic [LEN_W-1:0]  drn_cnt_reg;

    logic              slot_free, rd_en, load_empty, last_issue;
    logic [LEN_W-1:0]  rd_pos_plus1;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] frame_id_reg, payload_byte_reg;
    logic [IDX_W-1:0]  byte_index_reg;
    logic [LEN_W-1:0]  frame_length_reg;
    logic              empty_frame_reg, last_reg;

    // Handshakes. Configuration is always taken.
    assign cfg_ready = 1'b1;
    assign in_stall  = drn_state_reg != DRN_IDLE;
    assign in_accept = in_valid && !in_stall;

    xcfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (in_accept),
        .rx_byte    (rx_byte),
        .evt        (evt)
    );

    // Payload memory: written by the parser, read by the drain sequencer.
    always_ff @(posedge clk)
    begin
        if (evt.wr_en)
            mem[AW'(evt.wr_pos)] <= evt.wr_data;
        if (rd_en)
            rd_data_reg <= mem[AW'(rd_idx_reg)];
    end

    // Drain control terms.
    always_comb
    begin
        slot_free    = !out_valid_reg || !out_stall;
        rd_pos_plus1 = {1'b0, rd_idx_reg} + LEN_W'(1);
        last_issue   = rd_pos_plus1 == drn_cnt_reg;
    end

    // Drain sequencer: next state.
    always_comb
    begin
        drn_state_next = drn_state_reg;
        unique case (drn_state_reg)
            DRN_IDLE:
            begin
                if (evt.done)
                    drn_state_next = (evt.length == '0) ? DRN_EMPTY : DRN_READ;
            end
            DRN_EMPTY:
            begin
                if (load_empty)
                    drn_state_next = DRN_IDLE;
            end
            DRN_READ:
            begin
                if (rd_en && last_issue)
                    drn_state_next = DRN_IDLE;
            end
            default: drn_state_next = DRN_IDLE;
        endcase
    end

    // Drain sequencer: outputs. A read is issued only when the output
    // register will be free as its data arrives.
    always_comb
    begin
        rd_en      = 1'b0;
        load_empty = 1'b0;
        unique case (drn_state_reg)
            DRN_IDLE:  ;
            DRN_EMPTY: load_empty = slot_free && !rd_pend_reg;
            DRN_READ:  rd_en      = slot_free && !rd_pend_reg;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drn_state_reg <= DRN_IDLE;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            drn_state_reg <= drn_state_next;
            rd_pend_reg   <= rd_en;
            if (evt.done)
                rd_idx_reg <= '0;
            else if (rd_en)
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
    end

    // Frame fields held for the drain, and the tag of the read in flight.
    always_ff @(posedge clk)
    begin
        if (evt.done)
        begin
            drn_id_reg  <= evt.id;
            drn_len_reg <= evt.length;
            drn_cnt_reg <= (evt.length > LEN_W'(MAX_RES)) ? LEN_W'(MAX_RES) : evt.length;
        end
        if (rd_en)
        begin
            pend_idx_reg  <= rd_idx_reg;
            pend_last_reg <= rd_pos_plus1 == drn_len_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rd_pend_reg || load_empty)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            frame_id_reg     <= drn_id_reg;
            payload_byte_reg <= rd_data_reg;
            byte_index_reg   <= pend_idx_reg;
            frame_length_reg <= drn_len_reg;
            empty_frame_reg  <= 1'b0;
            last_reg         <= pend_last_reg;
        end
        else if (load_empty)
        begin
            frame_id_reg     <= drn_id_reg;
            payload_byte_reg <= '0;
            byte_index_reg   <= '0;
            frame_length_reg <= drn_len_reg;
            empty_frame_reg  <= 1'b1;
            last_reg         <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_id     = frame_id_reg;
    assign payload_byte = payload_byte_reg;
    assign byte_index   = byte_index_reg;
    assign frame_length = frame_length_reg;
    assign empty_frame  = empty_frame_reg;
    assign last         = last_reg;

    // The parser never writes the payload memory while a drain is running.
    `XCFR_ASSERT_NOW(a_no_write_in_drain, clk, rst_n, drn_state_reg != DRN_IDLE, !evt.wr_en)
    // Read data always lands in an empty output register.
    `XCFR_ASSERT_NOW(a_pend_slot_empty, clk, rst_n, rd_pend_reg, !out_valid_reg)
    // A new frame is accepted only with the drain sequencer idle.
    `XCFR_ASSERT_NOW(a_done_when_idle, clk, rst_n, evt.done, drn_state_reg == DRN_IDLE)
    // An issued read is followed by a loaded output.
    `XCFR_ASSERT_NEXT(a_read_loads_out, clk, rst_n, rd_en, rd_pend_reg)

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xcfr_pkg::*;

    localparam int CLK_PERIOD           = 4;
    localparam int RESET_CYCLES         = 12;
    localparam int PAYLOAD_DEPTH        = 32;
    localparam int RAND_BYTES_PER_PHASE = 28;
    localparam int SETTLE_CYCLES        = 10;
    localparam int CYCLE_LIMIT          = 400000;
    localparam int NUM_PHASES           = 4;
    localparam int NUM_REGS             = 8;

    // An index beyond the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 4'd12;

    // One payload result as seen on the output port.
    typedef struct {
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  byte_index;
        logic [LEN_W-1:0]  frame_length;
        logic              empty_frame;
        logic              last;
    } frame_result_t;

    // Frame parser mirror plus the queue of payload results still owed.
    class frame_scoreboard;
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [LEN_W-1:0]  max_len;
        logic [BYTE_W-1:0] accept_ids[5];
        parse_step_t       step;
        logic [BYTE_W-1:0] run_xor;
        int                bytes_left;
        int                held_len;
        logic [BYTE_W-1:0] held_id;
        logic [BYTE_W-1:0] payload_mem[PAYLOAD_DEPTH];
        frame_result_t     owed_results[$];
        int                errors;
        int                rx_count;
        int                frame_count;
        int                owed_count;
        int                checked_count;

        function new();
            start_byte = 8'd2;
            end_byte   = 8'd3;
            max_len    = 6'd32;
            foreach (accept_ids[i])
                accept_ids[i] = 8'(i + 1);
            step          = PS_SOF;
            run_xor       = '0;
            bytes_left    = 0;
            held_len      = 0;
            held_id       = '0;
            errors        = 0;
            rx_count      = 0;
            frame_count   = 0;
            owed_count    = 0;
            checked_count = 0;
        endfunction

        function int len_limit();
            return (int'(max_len) < PAYLOAD_DEPTH) ? int'(max_len) : PAYLOAD_DEPTH;
        endfunction

        function bit id_known(logic [BYTE_W-1:0] id);
            foreach (accept_ids[i])
                if (accept_ids[i] == id)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
            unique case (idx)
                CFG_START:   start_byte = data;
                CFG_END:     end_byte = data;
                CFG_MAX_LEN: max_len = data[LEN_W-1:0];
                CFG_ID_A:    accept_ids[0] = data;
                CFG_ID_B:    accept_ids[1] = data;
                CFG_ID_C:    accept_ids[2] = data;
                CFG_ID_D:    accept_ids[3] = data;
                CFG_ID_E:    accept_ids[4] = data;
                default:     ;
            endcase
        endfunction

        function void owe_result(logic [BYTE_W-1:0] data, int idx, bit empty, bit fin);
            frame_result_t r;
            r.frame_id     = held_id;
            r.payload_byte = data;
            r.byte_index   = IDX_W'(idx);
            r.frame_length = LEN_W'(held_len);
            r.empty_frame  = empty;
            r.last         = fin;
            owed_results.push_back(r);
            owed_count++;
        endfunction

        // Advance the parser by one received byte and queue what it releases.
        function void note_rx_byte(logic [BYTE_W-1:0] b);
            rx_count++;
            unique case (step)
                PS_SKIP:
                    if (b == end_byte)
                        step = PS_SOF;
                PS_LEN:
                    if (int'(b) > len_limit())
                        step = PS_SKIP;
                    else
                    begin
                        held_len   = int'(b);
                        bytes_left = int'(b);
                        run_xor    ^= b;
                        step       = PS_ID;
                    end
                PS_ID:
                    if (!id_known(b))
                        step = PS_SKIP;
                    else
                    begin
                        held_id = b;
                        run_xor ^= b;
                        step    = (bytes_left == 0) ? PS_CHK : PS_DATA;
                    end
                PS_DATA:
                begin
                    payload_mem[IDX_W'(held_len - bytes_left)] = b;
                    run_xor ^= b;
                    bytes_left--;
                    if (bytes_left == 0)
                        step = PS_CHK;
                end
                PS_CHK:
                    step = (b == run_xor) ? PS_EOT : PS_SKIP;
                PS_EOT:
                    if (b != end_byte)
                        step = PS_SKIP;
                    else
                    begin
                        step = PS_SOF;
                        frame_count++;
                        if (held_len == 0)
                            owe_result('0, 0, 1'b1, 1'b1);
                        else
                            for (int i = 0; i < held_len; i++)
                                owe_result(payload_mem[IDX_W'(i)], i, 1'b0,
                                           i + 1 == held_len);
                    end
                default:
                    if (b != start_byte)
                        step = PS_SKIP;
                    else
                    begin
                        run_xor    = '0;
                        bytes_left = 0;
                        step       = PS_LEN;
                    end
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result with nothing owed: frame_id %0d payload_byte %0d",
                       got.frame_id, got.payload_byte);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            checked_count++;
            compare_field("frame_id", 32'(want.frame_id), 32'(got.frame_id));
            compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            compare_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
            compare_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
            compare_field("empty_frame", 32'(want.empty_frame), 32'(got.empty_frame));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [BYTE_W-1:0]    frame_id;
    logic [BYTE_W-1:0]    payload_byte;
    logic [IDX_W-1:0]     byte_index;
    logic [LEN_W-1:0]     frame_length;
    logic                 empty_frame;
    logic                 last;

    int          gap_pct = 0;
    int          stall_pct = 0;
    int unsigned cycle_count = 0;

    frame_scoreboard sb = new();

    // Register settings per phase: start, end, max_len, then the five ids.
    logic [BYTE_W-1:0] reg_plan [NUM_PHASES][NUM_REGS] = '{
        '{8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h7E, 8'h81, 8'h10},
        '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'h55},
        '{8'h7E, 8'h7F, 8'h45, 8'h20, 8'h20, 8'h20, 8'h20, 8'hC3},
        '{8'h5A, 8'hA5, 8'h20, 8'hAA, 8'h55, 8'h33, 8'hCC, 8'h0F}
    };
    int phase_gap   [NUM_PHASES] = '{0, 57, 0, 19};
    int phase_stall [NUM_PHASES] = '{0, 0, 57, 19};

    xor_checked_frame_receiver i_dut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Random back-pressure on the result side.
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Every accepted result is checked against the oldest owed one.
    always @(posedge clk)
    begin : watch_results
        frame_result_t got;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got.frame_id     = frame_id;
            got.payload_byte = payload_byte;
            got.byte_index   = byte_index;
            got.frame_length = frame_length;
            got.empty_frame  = empty_frame;
            got.last         = last;
            sb.check_result(got);
        end
    end

    // Offer one byte after a random gap and hold it until it is taken.
    task automatic send_byte(logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_rx_byte(b);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    // Hold the input until every owed result is out, then let the block settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.owed_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Feed end bytes until the parser is back to waiting for a start byte.
    task automatic resync();
        while (sb.step != PS_SOF)
            send_byte(sb.end_byte);
    endtask

    task automatic send_frame(logic [BYTE_W-1:0] id, int len, bit bad_chk, bit bad_end);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] tail;
        sum = 8'(len) ^ id;
        send_byte(sb.start_byte);
        send_byte(8'(len));
        send_byte(id);
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            sum ^= b;
            send_byte(b);
        end
        if (bad_chk)
            sum ^= 8'($urandom_range(1, 255));
        send_byte(sum);
        tail = sb.end_byte;
        if (bad_end)
            tail ^= 8'($urandom_range(1, 255));
        send_byte(tail);
    endtask

    // Mostly good frames with random content; the rest are broken or noise.
    task automatic random_frame();
        int                kind;
        int                limit;
        int                len;
        logic [BYTE_W-1:0] id;
        limit = sb.len_limit();
        if ($urandom_range(0, 7) == 0)
            len = limit;
        else
            len = $urandom_range(0, (limit < 6) ? limit : 6);
        id   = sb.accept_ids[3'($urandom_range(0, 4))];
        kind = $urandom_range(0, 99);
        if (kind < 70)
            send_frame(id, len, 1'b0, 1'b0);
        else if (kind < 76)
            send_frame(id, len, 1'b1, 1'b0);
        else if (kind < 82)
            send_frame(id, len, 1'b0, 1'b1);
        else if (kind < 88)
        begin
            send_byte(sb.start_byte);
            send_byte(8'($urandom_range(limit + 1, 255)));
        end
        else if (kind < 94)
        begin
            do
                id = 8'($urandom);
            while (sb.id_known(id));
            send_byte(sb.start_byte);
            send_byte(8'(len));
            send_byte(id);
        end
        else
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        resync();
        // Now and then the sender waits for the output side to catch up.
        if ($urandom_range(0, 9) == 0)
            wait_drained();
    endtask

    initial
    begin
        int sent_mark;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed cases under the reset settings, no idling.
        send_frame(sb.accept_ids[0], 0, 1'b0, 1'b0);
        send_byte(8'h55);
        resync();
        send_byte(sb.start_byte);
        send_byte(8'd33);
        resync();
        send_byte(sb.start_byte);
        send_byte(8'd0);
        send_byte(8'h06);
        resync();
        send_frame(sb.accept_ids[4], 2, 1'b1, 1'b0);
        resync();
        send_frame(sb.accept_ids[3], 2, 1'b0, 1'b0);

        // Random phases, each with its own register setting and idle pattern.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            for (int i = 0; i < NUM_REGS; i++)
                write_reg(cfg_reg_t'(i), reg_plan[2'(ph)][3'(i)]);
            if (ph == 2)
                write_reg(CFG_NO_REG, 8'h99);
            cfg_valid <= 1'b0;
            gap_pct   = phase_gap[2'(ph)];
            stall_pct = phase_stall[2'(ph)];
            sent_mark = sb.rx_count;
            while (sb.rx_count - sent_mark < RAND_BYTES_PER_PHASE)
                random_frame();
        end
        wait_drained();

        $display("summary: %0d bytes in, %0d frames accepted, %0d results owed, %0d checked",
                 sb.rx_count, sb.frame_count, sb.owed_count, sb.checked_count);
        $display("summary: %0d register settings, max_len from 0 to 63, idle up to 57 pct",
                 NUM_PHASES + 1);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
